>>> rtl/ssv_pkg.sv
// shared types and constants for the sorted symbol vocabulary
// command and result words, cell probe flags, mode and status codes
// no dependencies
package ssv_pkg;

  // one input word
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
    logic [7:0] position;
    logic       end_of_text;
  } command_t;

  // one result word
  typedef struct packed {
    logic [7:0] symbol_out;
    logic [7:0] rank;
    logic [1:0] status;
    logic [8:0] entries;
    logic       last_out;
  } result_t;

  // registered compare flags of one cell
  typedef struct packed {
    logic       first_ge;
    logic       eq;
    logic [7:0] pick;
  } probe_t;

  // registered summary of one group of cells
  typedef struct packed {
    logic       first_seen;
    logic       found;
    logic [7:0] pick;
  } group_sum_t;

  // mode codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_DECODE = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_MISS    = 2'd2;
  localparam logic [1:0] STATUS_FULL    = 2'd3;

  // cells per reduction group
  localparam int GROUP_SIZE = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_REDUCE,
    S_FINISH
  } state_t;

endpackage

>>> rtl/sorted_symbol_vocabulary.sv
// a taken word is held, then passes through the compare, group reduce and finish
// states before its result strobe; a new word may already be taken in the finish state
// the cell compare, the group or-tree and the finish stage are those steps
// reset: entry count cleared, sequencer idle, no strobe; table bytes undefined
// and never read before written, so there is no clearing pass
// the receiver cannot stall: the done strobe is high for one cycle only
module sorted_symbol_vocabulary import ssv_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  command_t command,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  // sequencer
  state_t state, state_next;
  logic   accept;
  logic   probe_en;
  logic   reduce_en;
  logic   finish;

  // held command word and table fill
  command_t         cmd;
  logic [CNT_W-1:0] count, count_next;

  // chain of cells
  logic [7:0]            cell_data [CAPACITY];
  logic [CAPACITY-1:0]   lt_now;
  logic [CAPACITY-1:0]   lt_q;
  probe_t [CAPACITY-1:0] probes;
  logic                  shift_en;

  // group summaries
  group_sum_t       gsum [NUM_GROUPS];
  logic [IDX_W-1:0] gat  [NUM_GROUPS];

  // final combine
  logic             found;
  logic             first_seen;
  logic [7:0]       pick;
  logic [IDX_W-1:0] at;
  logic             full;
  result_t          result_next;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = S_COMPARE;
      S_COMPARE: state_next = S_REDUCE;
      S_REDUCE:  state_next = S_FINISH;
      S_FINISH:  state_next = start ? S_COMPARE : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // sequencer outputs; a new word may enter during the finish cycle
  always_comb begin
    busy      = 1'b0;
    probe_en  = 1'b0;
    reduce_en = 1'b0;
    finish    = 1'b0;
    case (state)
      S_IDLE:    ;
      S_COMPARE: begin
        busy     = 1'b1;
        probe_en = 1'b1;
      end
      S_REDUCE:  begin
        busy      = 1'b1;
        reduce_en = 1'b1;
      end
      S_FINISH:  finish = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= command;
    end
    if (finish) begin
      result <= result_next;
    end
  end

  // compare-and-shift cells, each one talks to its lower neighbour only
  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    if (c == 0) begin : g_first
      ssv_cell #(.INDEX(c), .CNT_W(CNT_W)) u_cell (
        .clk         (clk),
        .symbol      (cmd.symbol),
        .position    (cmd.position),
        .count       (count),
        .probe_en    (probe_en),
        .shift_en    (shift_en),
        .prev_lt_now (1'b1),
        .prev_lt     (1'b1),
        .prev_data   (8'd0),
        .lt_now      (lt_now[c]),
        .lt          (lt_q[c]),
        .data        (cell_data[c]),
        .probe       (probes[c])
      );
    end else begin : g_next
      ssv_cell #(.INDEX(c), .CNT_W(CNT_W)) u_cell (
        .clk         (clk),
        .symbol      (cmd.symbol),
        .position    (cmd.position),
        .count       (count),
        .probe_en    (probe_en),
        .shift_en    (shift_en),
        .prev_lt_now (lt_now[c-1]),
        .prev_lt     (lt_q[c-1]),
        .prev_data   (cell_data[c-1]),
        .lt_now      (lt_now[c]),
        .lt          (lt_q[c]),
        .data        (cell_data[c]),
        .probe       (probes[c])
      );
    end
  end

  // first level of the reduction tree, registered per group
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    localparam int BASE = g * GROUP_SIZE;
    localparam int SIZE = (CAPACITY - BASE < GROUP_SIZE) ? CAPACITY - BASE : GROUP_SIZE;
    ssv_group #(.BASE(BASE), .SIZE(SIZE), .IDX_W(IDX_W)) u_group (
      .clk    (clk),
      .en     (reduce_en),
      .probes (probes[BASE +: SIZE]),
      .sum    (gsum[g]),
      .at     (gat[g])
    );
  end

  // second level: or the group summaries together
  always_comb begin
    found      = 1'b0;
    first_seen = 1'b0;
    pick       = '0;
    at         = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      found      = found | gsum[g].found;
      first_seen = first_seen | gsum[g].first_seen;
      pick       = pick | gsum[g].pick;
      at         = at | gat[g];
    end
  end

  // result word, table update and fill count
  always_comb begin
    full        = count == CNT_W'(CAPACITY);
    shift_en    = 1'b0;
    count_next  = count;
    result_next = '0;
    result_next.symbol_out = cmd.symbol;
    result_next.rank       = 8'd0;
    result_next.status     = STATUS_MISS;
    result_next.last_out   = cmd.end_of_text;
    case (cmd.mode)
      MODE_INSERT: begin
        if (found) begin
          result_next.status = STATUS_PRESENT;
          result_next.rank   = 8'(at);
        end else if (full || !first_seen) begin
          result_next.status = STATUS_FULL;
        end else begin
          result_next.status = STATUS_OK;
          result_next.rank   = 8'(at);
          shift_en           = finish;
          if (finish) begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      MODE_ENCODE: begin
        if (found) begin
          result_next.status = STATUS_OK;
          result_next.rank   = 8'(at);
        end
      end
      MODE_DECODE: begin
        result_next.rank = cmd.position;
        if ({1'b0, cmd.position} < 9'(count)) begin
          result_next.symbol_out = pick;
          result_next.status     = STATUS_OK;
        end else begin
          result_next.symbol_out = 8'd0;
        end
      end
      default: ;
    endcase
    result_next.entries = 9'(count_next);
  end

`ifndef SYNTHESIS
  // the fill count never runs past the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // every accepted word gets its result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("result strobe missing after accepted word");

  // a strobe only follows a finish cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(finish))
    else $error("result strobe without finish cycle");

  // the table only grows by one on a successful insert
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CNT_W'(1)) && $past(shift_en))
    else $error("entry count changed without insert");
`endif

endmodule

>>> rtl/ssv_cell.sv
// one slot of the sorted table: holds a byte, compares it and shifts it up
// depends on ssv_pkg
module ssv_cell import ssv_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic [7:0]       symbol,
  input  logic [7:0]       position,
  input  logic [CNT_W-1:0] count,
  input  logic             probe_en,
  input  logic             shift_en,
  input  logic             prev_lt_now,
  input  logic             prev_lt,
  input  logic [7:0]       prev_data,
  output logic             lt_now,
  output logic             lt,
  output logic [7:0]       data,
  output probe_t           probe
);

  logic held;

  always_comb begin
    held   = CNT_W'(INDEX) < count;
    lt_now = held && (data < symbol);
  end

  always_ff @(posedge clk) begin
    if (probe_en) begin
      lt             <= lt_now;
      probe.first_ge <= !lt_now && prev_lt_now;
      probe.eq       <= held && (data == symbol);
      probe.pick     <= (position == 8'(INDEX)) ? data : 8'd0;
    end
    // smaller entries stay, the insert place takes the symbol, the rest move up
    if (shift_en && !lt) begin
      data <= prev_lt ? symbol : prev_data;
    end
  end

endmodule

>>> rtl/ssv_group.sv
// registered or-reduction of the probe flags of one group of cells
// depends on ssv_pkg
module ssv_group import ssv_pkg::*; #(
  parameter int BASE  = 0,
  parameter int SIZE  = 16,
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               en,
  input  probe_t [SIZE-1:0]  probes,
  output group_sum_t         sum,
  output logic [IDX_W-1:0]   at
);

  group_sum_t       sum_next;
  logic [IDX_W-1:0] at_next;

  always_comb begin
    sum_next = '0;
    at_next  = '0;
    for (int j = 0; j < SIZE; j++) begin
      sum_next.first_seen = sum_next.first_seen | probes[j].first_ge;
      sum_next.found      = sum_next.found | probes[j].eq;
      sum_next.pick       = sum_next.pick | probes[j].pick;
      if (probes[j].first_ge) begin
        at_next = at_next | IDX_W'(BASE + j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
      at  <= at_next;
    end
  end

endmodule

>>> sim/tb_top.sv
// testbench for sorted_symbol_vocabulary: insert, encode and decode words with self-checking
// needs ssv_pkg (word structs, mode and status codes) and the sorted_symbol_vocabulary rtl
module tb_top import ssv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // table depth the block is built with; the shadow table follows it
  localparam int CAP = 256;
  // the one mode code that the package leaves unnamed
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // slowest run is roughly 550 words plus short gaps, so this is many times over
  localparam int CYCLE_LIMIT = 100000;
  // extra cycles run once the last due result word has been checked
  localparam int DRAIN_CYCLES = 8;

  // one line of the directed table: the word, and a typed expectation where
  // it can be read off directly
  typedef struct {
    command_t word;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  command_t command = '0;
  logic     busy;
  logic     done;
  result_t  result;

  // shadow of the sorted table and its fill level
  logic [7:0]  shadow_symbols [CAP];
  int          shadow_count = 0;
  // expected result words, oldest first
  result_t     due_results [$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned cycles = 0;
  // sender gaps on or off
  bit          idle_allowed = 1'b0;

  sorted_symbol_vocabulary #(.CAPACITY(CAP)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one word to the shadow table and returns the result it gives
  function automatic result_t vocab_apply(command_t c);
    result_t r;
    int      at;
    r.symbol_out = c.symbol;
    r.rank       = '0;
    r.status     = STATUS_MISS;
    r.last_out   = c.end_of_text;
    // sorted place: count of held bytes strictly below the symbol
    at = 0;
    while (at < shadow_count && shadow_symbols[at] < c.symbol) at++;
    case (c.mode)
      MODE_INSERT: begin
        if (at < shadow_count && shadow_symbols[at] == c.symbol) begin
          r.status = STATUS_PRESENT;
          r.rank   = 8'(at);
        end else if (shadow_count >= CAP) begin
          r.status = STATUS_FULL;
        end else begin
          // larger entries move up one slot
          for (int i = shadow_count; i > at; i--) shadow_symbols[i] = shadow_symbols[i - 1];
          shadow_symbols[at] = c.symbol;
          shadow_count++;
          r.status = STATUS_OK;
          r.rank   = 8'(at);
        end
      end
      MODE_ENCODE: begin
        if (at < shadow_count && shadow_symbols[at] == c.symbol) begin
          r.status = STATUS_OK;
          r.rank   = 8'(at);
        end
      end
      MODE_DECODE: begin
        r.rank = c.position;
        if (int'(c.position) < shadow_count) begin
          r.symbol_out = shadow_symbols[c.position];
          r.status     = STATUS_OK;
        end else begin
          r.symbol_out = '0;
        end
      end
      default: begin
        // spare mode: echo only, table untouched
      end
    endcase
    r.entries = 9'(shadow_count);
    return r;
  endfunction

  function automatic stim_row_t vocab_row(logic [1:0] m, logic [7:0] s, logic [7:0] p,
                                          logic eot, bit typed, logic [7:0] s_out,
                                          logic [7:0] rk, logic [1:0] st, logic [8:0] ent);
    stim_row_t row;
    row.word.mode        = m;
    row.word.symbol      = s;
    row.word.position    = p;
    row.word.end_of_text = eot;
    row.typed            = typed;
    row.want.symbol_out  = s_out;
    row.want.rank        = rk;
    row.want.status      = st;
    row.want.entries     = ent;
    row.want.last_out    = eot;
    return row;
  endfunction

  // random word, mostly well formed: encodes tend to hit held bytes and
  // decodes tend to land inside the filled part of the table
  function automatic command_t rand_word();
    command_t    c;
    int unsigned pick;
    pick          = $urandom_range(99);
    c.symbol      = 8'($urandom_range(255));
    c.position    = 8'($urandom_range(255));
    c.end_of_text = ($urandom_range(7) == 0);
    if (pick < 40) c.mode = MODE_INSERT;
    else if (pick < 70) c.mode = MODE_ENCODE;
    else if (pick < 95) c.mode = MODE_DECODE;
    else c.mode = MODE_SPARE;
    if (shadow_count > 0) begin
      if (c.mode == MODE_INSERT && $urandom_range(9) < 3)
        c.symbol = shadow_symbols[$urandom_range(shadow_count - 1)];
      if (c.mode == MODE_ENCODE && $urandom_range(9) < 6)
        c.symbol = shadow_symbols[$urandom_range(shadow_count - 1)];
      if (c.mode == MODE_DECODE && $urandom_range(9) < 8)
        c.position = 8'($urandom_range(shadow_count - 1));
    end
    return c;
  endfunction

  // drive one word and hold it until the block takes it, then predict
  task automatic send_word(input command_t c, input bit typed, input result_t want);
    result_t predicted;
    // occasional sender gap, which may land on any phase of the block's work
    if (idle_allowed && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    // busy as seen here is the value before the edge
    do @(posedge clk); while (busy);
    predicted = vocab_apply(c);
    due_results.push_back(typed ? want : predicted);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result word %0d: %s", words_checked, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // result side: the strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        report_mismatch("result word with none due");
      end else begin
        want = due_results.pop_front();
        check_field("symbol_out", 9'(result.symbol_out), 9'(want.symbol_out));
        check_field("rank", 9'(result.rank), 9'(want.rank));
        check_field("status", 9'(result.status), 9'(want.status));
        check_field("entries", result.entries, want.entries);
        check_field("last_out", 9'(result.last_out), 9'(want.last_out));
      end
      words_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL sorted_symbol_vocabulary");
      $finish;
    end
  end

  initial begin
    stim_row_t  directed_rows [$];
    stim_row_t  row;
    logic [7:0] fill_order [256];
    logic [7:0] swap;
    int         j;

    // directed table, starting from an empty vocabulary
    // empty table: decode, encode and spare mode all miss
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'h00, 8'h00, 1'b0, 1'b1,
                                      8'h00, 8'h00, STATUS_MISS, 9'd0));
    directed_rows.push_back(vocab_row(MODE_ENCODE, 8'h41, 8'h00, 1'b1, 1'b1,
                                      8'h41, 8'h00, STATUS_MISS, 9'd0));
    directed_rows.push_back(vocab_row(MODE_SPARE, 8'hA5, 8'h3C, 1'b1, 1'b1,
                                      8'hA5, 8'h00, STATUS_MISS, 9'd0));
    // inserts at the middle, the bottom and the top of the byte range
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h80, 8'h00, 1'b0, 1'b1,
                                      8'h80, 8'h00, STATUS_OK, 9'd1));
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h00, 8'hFF, 1'b0, 1'b1,
                                      8'h00, 8'h00, STATUS_OK, 9'd2));
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'hFF, 8'h00, 1'b1, 1'b1,
                                      8'hFF, 8'h02, STATUS_OK, 9'd3));
    // duplicate insert leaves the table alone and reports where it sits
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h80, 8'h00, 1'b0, 1'b1,
                                      8'h80, 8'h01, STATUS_PRESENT, 9'd3));
    // neighbours either side of 0x80 shift the larger entries up
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h7F, 8'h00, 1'b0, 1'b1,
                                      8'h7F, 8'h01, STATUS_OK, 9'd4));
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h81, 8'h00, 1'b0, 1'b1,
                                      8'h81, 8'h03, STATUS_OK, 9'd5));
    // table is now 00 7f 80 81 ff
    directed_rows.push_back(vocab_row(MODE_ENCODE, 8'hFF, 8'h00, 1'b0, 1'b1,
                                      8'hFF, 8'h04, STATUS_OK, 9'd5));
    directed_rows.push_back(vocab_row(MODE_ENCODE, 8'h00, 8'hFF, 1'b1, 1'b1,
                                      8'h00, 8'h00, STATUS_OK, 9'd5));
    directed_rows.push_back(vocab_row(MODE_ENCODE, 8'h55, 8'h00, 1'b0, 1'b1,
                                      8'h55, 8'h00, STATUS_MISS, 9'd5));
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'h00, 8'h00, 1'b0, 1'b1,
                                      8'h00, 8'h00, STATUS_OK, 9'd5));
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'h00, 8'h04, 1'b0, 1'b1,
                                      8'hFF, 8'h04, STATUS_OK, 9'd5));
    // decode just past the end and at the top index
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'hFF, 8'h05, 1'b0, 1'b1,
                                      8'h00, 8'h05, STATUS_MISS, 9'd5));
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'h00, 8'hFF, 1'b1, 1'b1,
                                      8'h00, 8'hFF, STATUS_MISS, 9'd5));
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h00, 8'h00, 1'b0, 1'b1,
                                      8'h00, 8'h00, STATUS_PRESENT, 9'd5));
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'hFF, 8'h00, 1'b0, 1'b1,
                                      8'hFF, 8'h04, STATUS_PRESENT, 9'd5));
    // decode ignores the symbol field
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'hFF, 8'h02, 1'b0, 1'b1,
                                      8'h80, 8'h02, STATUS_OK, 9'd5));
    directed_rows.push_back(vocab_row(MODE_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b1,
                                      8'hFF, 8'h00, STATUS_MISS, 9'd5));
    // the rest left to the predictor
    directed_rows.push_back(vocab_row(MODE_INSERT, 8'h01, 8'h00, 1'b1, 1'b0,
                                      '0, '0, '0, '0));
    directed_rows.push_back(vocab_row(MODE_ENCODE, 8'h7F, 8'h00, 1'b0, 1'b0,
                                      '0, '0, '0, '0));
    directed_rows.push_back(vocab_row(MODE_DECODE, 8'h00, 8'h01, 1'b0, 1'b0,
                                      '0, '0, '0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_allowed = 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_word(row.word, row.typed, row.want);
    end

    // mixed traffic while the table fills slowly, duplicates included
    repeat (170) send_word(rand_word(), 1'b0, '0);

    // fill every byte value in random order, with no sender gaps at all;
    // already held bytes come back as duplicates, and entries reaches 256
    for (int k = 0; k < 256; k++) fill_order[k] = 8'(k);
    for (int k = 255; k > 0; k--) begin
      j             = $urandom_range(k);
      swap          = fill_order[k];
      fill_order[k] = fill_order[j];
      fill_order[j] = swap;
    end
    idle_allowed = 1'b0;
    foreach (fill_order[k]) begin
      row = vocab_row(MODE_INSERT, fill_order[k], 8'($urandom_range(255)),
                      ($urandom_range(7) == 0), 1'b0, '0, '0, '0, '0);
      send_word(row.word, 1'b0, '0);
    end
    idle_allowed = 1'b1;

    // full table: with every byte held, an insert can only be a duplicate,
    // so the table-full status cannot arise at this depth
    repeat (100) send_word(rand_word(), 1'b0, '0);

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS sorted_symbol_vocabulary");
    else
      $display("FAIL sorted_symbol_vocabulary");
    $finish;
  end

endmodule
